/* rtl/mft_pkg.sv */
package mft_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_COMMIT = 2'd1,
        MODE_START  = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    // Manchester symbols, first half in the upper bit.
    localparam logic [1:0] MANCH_ONE  = 2'b01;
    localparam logic [1:0] MANCH_ZERO = 2'b10;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned QUEUED_W = 4;

endpackage

/* rtl/mft_item_if.sv */
interface mft_item_if;
    logic                              valid;
    logic                              ready;
    mft_pkg::t_mode                    mode;
    logic [mft_pkg::BYTE_W-1:0]        data_byte;
    logic                              collision;
    logic                              channel_idle;

    modport source (output valid, mode, data_byte, collision, channel_idle, input ready);
    modport sink   (input valid, mode, data_byte, collision, channel_idle, output ready);
endinterface

/* rtl/mft_result_if.sv */
interface mft_result_if;
    logic                              valid;
    logic                              ready;
    logic                              line_out;
    logic                              transmitting;
    logic                              accepted;
    logic [mft_pkg::QUEUED_W-1:0]      frames_queued;

    modport source (output valid, line_out, transmitting, accepted, frames_queued,
                    input ready);
    modport sink   (input valid, line_out, transmitting, accepted, frames_queued,
                    output ready);
endinterface

/* rtl/mft_store.sv */
module mft_store #(
    parameter int unsigned QUEUE_DEPTH = 8,
    parameter int unsigned FRAME_BYTES = 512
) (
    input  logic                           i_clk,
    input  logic                           i_byte_we,
    input  logic [$clog2(QUEUE_DEPTH*FRAME_BYTES)-1:0] i_byte_waddr,
    input  logic [mft_pkg::BYTE_W-1:0]     i_byte_wdata,
    input  logic [$clog2(QUEUE_DEPTH*FRAME_BYTES)-1:0] i_byte_raddr,
    output logic [mft_pkg::BYTE_W-1:0]     o_byte_rdata,
    input  logic                           i_len_we,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_len_waddr,
    input  logic [$clog2(FRAME_BYTES+1)-1:0] i_len_wdata,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_len_raddr,
    output logic [$clog2(FRAME_BYTES+1)-1:0] o_len_rdata
);
    localparam int unsigned StoreDepth = QUEUE_DEPTH * FRAME_BYTES;
    localparam int unsigned LenW       = $clog2(FRAME_BYTES + 1);

    logic [mft_pkg::BYTE_W-1:0] r_bytes [StoreDepth];
    logic [LenW-1:0]            r_lens  [QUEUE_DEPTH];
    logic [mft_pkg::BYTE_W-1:0] r_byte_rdata;
    logic [LenW-1:0]            r_len_rdata;

    // Both stores read write-first, so a value written in this cycle is
    // seen on the next one at the same address.
    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            r_bytes[i_byte_waddr] <= i_byte_wdata;
        end
        if (i_byte_we && (i_byte_waddr == i_byte_raddr)) begin
            r_byte_rdata <= i_byte_wdata;
        end else begin
            r_byte_rdata <= r_bytes[i_byte_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            r_lens[i_len_waddr] <= i_len_wdata;
        end
        if (i_len_we && (i_len_waddr == i_len_raddr)) begin
            r_len_rdata <= i_len_wdata;
        end else begin
            r_len_rdata <= r_lens[i_len_raddr];
        end
    end

    assign o_byte_rdata = r_byte_rdata;
    assign o_len_rdata  = r_len_rdata;

endmodule

/* rtl/manchester_frame_transmitter.sv */
// Channel    Dir  Handshake      Payload
// i_item     in   valid/ready    mode, data_byte, collision, channel_idle
// o_result   out  valid/ready    line_out, transmitting, accepted, frames_queued
//
// Every item is decoded against the current state, and its result is loaded
// into the output register on the edge of its transfer.
// A new item is taken in every cycle while the output register is empty or
// being emptied. The head byte and head length come from registered store
// reads that are addressed with next-cycle state, so they are always current.
// Reset (synchronous, active low) empties the queue and drives the line high;
// the frame stores themselves are not cleared.
module manchester_frame_transmitter #(
    parameter int unsigned QUEUE_DEPTH = 8,
    parameter int unsigned FRAME_BYTES = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mft_item_if.sink     i_item,
    mft_result_if.source o_result
);
    localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned LW  = $clog2(FRAME_BYTES + 1);
    localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned AW  = $clog2(QUEUE_DEPTH * FRAME_BYTES);

    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_queued, n_queued;
    logic [LW-1:0] r_build, n_build;
    logic          r_running, n_running;
    logic [LW-1:0] r_byte_pos, n_byte_pos;
    logic [2:0]    r_bit_pos, n_bit_pos;
    logic          r_half, n_half;
    logic          r_line, n_line;

    logic                              r_out_valid;
    logic                              r_out_line;
    logic                              r_out_running;
    logic                              r_out_acc;
    logic [mft_pkg::QUEUED_W-1:0]      r_out_queued;

    logic                              xfer;
    logic                              acc;
    logic                              byte_we;
    logic                              len_we;
    logic [AW-1:0]                     byte_waddr;
    logic [AW-1:0]                     byte_raddr;
    logic [mft_pkg::BYTE_W-1:0]        head_byte;
    logic [LW-1:0]                     head_len;

    function automatic logic [AW-1:0] store_addr(logic [QW-1:0] slot, logic [LW-1:0] pos);
        logic [AW-1:0] base;
        base = AW'(slot) * AW'(FRAME_BYTES);
        // A position at the frame end is never read; keep the address in range.
        if (pos >= LW'(FRAME_BYTES)) begin
            return base;
        end
        return base + AW'(pos);
    endfunction

    function automatic logic [QW-1:0] slot_inc(logic [QW-1:0] slot);
        return (slot == QW'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    assign xfer         = i_item.valid && i_item.ready;
    assign i_item.ready = !r_out_valid || o_result.ready;

    always_comb begin
        logic          bit_val;
        logic [1:0]    symbol;
        n_head     = r_head;
        n_tail     = r_tail;
        n_queued   = r_queued;
        n_build    = r_build;
        n_running  = r_running;
        n_byte_pos = r_byte_pos;
        n_bit_pos  = r_bit_pos;
        n_half     = r_half;
        n_line     = r_line;
        acc        = 1'b0;
        byte_we    = 1'b0;
        len_we     = 1'b0;
        bit_val    = head_byte[3'd7 - r_bit_pos];
        symbol     = bit_val ? mft_pkg::MANCH_ONE : mft_pkg::MANCH_ZERO;
        if (xfer) begin
            unique case (i_item.mode) inside
                mft_pkg::MODE_WRITE: begin
                    if (r_build < LW'(FRAME_BYTES) && r_queued < CW'(QUEUE_DEPTH)) begin
                        byte_we = 1'b1;
                        n_build = r_build + 1'b1;
                        acc     = 1'b1;
                    end
                end
                mft_pkg::MODE_COMMIT, mft_pkg::MODE_START: begin
                    if (i_item.mode == mft_pkg::MODE_COMMIT
                        && r_queued < CW'(QUEUE_DEPTH)) begin
                        len_we   = 1'b1;
                        n_tail   = slot_inc(r_tail);
                        n_queued = r_queued + 1'b1;
                        n_build  = '0;
                        acc      = 1'b1;
                    end
                    if (i_item.channel_idle && !r_running && n_queued != '0) begin
                        n_running  = 1'b1;
                        n_byte_pos = '0;
                        n_bit_pos  = '0;
                        n_half     = 1'b0;
                    end
                end
                mft_pkg::MODE_TICK: begin
                    if (r_running) begin
                        if (i_item.collision || r_byte_pos >= head_len) begin
                            n_running  = 1'b0;
                            n_byte_pos = '0;
                            n_bit_pos  = '0;
                            n_half     = 1'b0;
                            n_line     = 1'b1;
                            if (!i_item.collision) begin
                                n_head   = slot_inc(r_head);
                                n_queued = r_queued - 1'b1;
                            end
                        end else begin
                            n_line = r_half ? symbol[0] : symbol[1];
                            n_half = !r_half;
                            if (r_half) begin
                                n_bit_pos = r_bit_pos + 1'b1;
                                if (r_bit_pos == 3'd7) begin
                                    n_byte_pos = r_byte_pos + 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign byte_waddr = store_addr(r_tail, r_build);
    assign byte_raddr = store_addr(n_head, n_byte_pos);

    mft_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_store (
        .i_clk        (i_clk),
        .i_byte_we    (byte_we),
        .i_byte_waddr (byte_waddr),
        .i_byte_wdata (i_item.data_byte),
        .i_byte_raddr (byte_raddr),
        .o_byte_rdata (head_byte),
        .i_len_we     (len_we),
        .i_len_waddr  (r_tail),
        .i_len_wdata  (r_build),
        .i_len_raddr  (n_head),
        .o_len_rdata  (head_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_queued    <= '0;
            r_build     <= '0;
            r_running   <= 1'b0;
            r_byte_pos  <= '0;
            r_bit_pos   <= '0;
            r_half      <= 1'b0;
            r_line      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_queued   <= n_queued;
            r_build    <= n_build;
            r_running  <= n_running;
            r_byte_pos <= n_byte_pos;
            r_bit_pos  <= n_bit_pos;
            r_half     <= n_half;
            r_line     <= n_line;
            if (xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_out_line    <= n_line;
            r_out_running <= n_running;
            r_out_acc     <= acc;
            r_out_queued  <= mft_pkg::QUEUED_W'(n_queued);
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.line_out      = r_out_line;
    assign o_result.transmitting  = r_out_running;
    assign o_result.accepted      = r_out_acc;
    assign o_result.frames_queued = r_out_queued;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_queued <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_run_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_queued != '0))
        else $error("serializer running with an empty queue");

    a_idle_line_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> r_line)
        else $error("line not high while stopped");

    a_build_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_build <= LW'(FRAME_BYTES))
        else $error("frame under construction too long");

endmodule

/* bench/manchester_frame_transmitter_test.sv */
`timescale 1ns / 100ps

module manchester_frame_transmitter_test;

    localparam int unsigned QUEUE_DEPTH  = 8;
    localparam int unsigned FRAME_BYTES  = 512;
    localparam int unsigned SLOT_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned LEN_W        = $clog2(FRAME_BYTES + 1);
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    typedef struct {
        mft_pkg::t_mode             mode;
        logic [mft_pkg::BYTE_W-1:0] data_byte;
        logic                       collision;
        logic                       channel_idle;
    } t_line_item;

    typedef struct packed {
        logic                         line_out;
        logic                         transmitting;
        logic                         accepted;
        logic [mft_pkg::QUEUED_W-1:0] frames_queued;
    } t_line_state;

    logic i_clk;
    logic i_rst_n;

    mft_item_if   item_bus ();
    mft_result_if result_bus ();

    manchester_frame_transmitter #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .FRAME_BYTES(FRAME_BYTES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_result(result_bus)
    );

    // Shadow copy of the transmitter state.
    logic [mft_pkg::BYTE_W-1:0]   byte_store [QUEUE_DEPTH*FRAME_BYTES];
    logic [LEN_W-1:0]             frame_len  [QUEUE_DEPTH];
    logic [SLOT_W-1:0]            head_q;
    logic [SLOT_W-1:0]            tail_q;
    logic [mft_pkg::QUEUED_W-1:0] queued;
    logic [LEN_W-1:0]             build_len;
    logic [LEN_W-1:0]             tx_byte;
    logic [2:0]                   tx_bit;
    logic                         tx_half;
    logic                         tx_running;
    logic                         line_lvl;

    t_line_item  items_to_send [$];
    t_line_state line_states_due [$];

    int unsigned items_total;
    int unsigned frames_sent;
    int unsigned collisions_seen;
    int unsigned rejects_seen;
    int unsigned error_count;
    int unsigned cycle_count;

    bit          item_taken;
    bit          steady;
    int unsigned phase_left;
    int unsigned gap_left;
    int unsigned stall_left;
    t_line_item  next_item;
    t_line_state want;

    function automatic logic [SLOT_W-1:0] slot_after(logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic void rewind_frame();
        tx_byte = '0;
        tx_bit  = '0;
        tx_half = 1'b0;
    endfunction

    function automatic void try_launch(logic idle);
        if (idle && !tx_running && queued != 0) begin
            tx_running = 1'b1;
            rewind_frame();
        end
    endfunction

    function automatic t_line_state transmitter_step(t_line_item it);
        t_line_state r;
        logic        bit_val;
        r.accepted = 1'b0;
        case (it.mode)
            mft_pkg::MODE_WRITE: begin
                if (build_len < FRAME_BYTES && queued < QUEUE_DEPTH) begin
                    byte_store[int'(tail_q) * FRAME_BYTES + int'(build_len)] = it.data_byte;
                    build_len  = build_len + 1'b1;
                    r.accepted = 1'b1;
                end else begin
                    rejects_seen++;
                end
            end
            mft_pkg::MODE_COMMIT: begin
                if (queued < QUEUE_DEPTH) begin
                    frame_len[tail_q] = build_len;
                    tail_q     = slot_after(tail_q);
                    queued     = queued + 1'b1;
                    build_len  = '0;
                    r.accepted = 1'b1;
                end else begin
                    rejects_seen++;
                end
                try_launch(it.channel_idle);
            end
            mft_pkg::MODE_START: begin
                try_launch(it.channel_idle);
            end
            default: begin
                if (tx_running) begin
                    if (it.collision) begin
                        // The frame stays at the head and is sent again from its start.
                        tx_running = 1'b0;
                        rewind_frame();
                        line_lvl = 1'b1;
                        collisions_seen++;
                    end else if (tx_byte >= frame_len[head_q]) begin
                        tx_running = 1'b0;
                        rewind_frame();
                        line_lvl = 1'b1;
                        head_q   = slot_after(head_q);
                        if (queued != 0) begin
                            queued = queued - 1'b1;
                        end
                        frames_sent++;
                    end else begin
                        bit_val  = byte_store[int'(head_q) * FRAME_BYTES
                                              + int'(tx_byte)][7 - tx_bit];
                        line_lvl = tx_half ? bit_val : ~bit_val;
                        if (!tx_half) begin
                            tx_half = 1'b1;
                        end else begin
                            tx_half = 1'b0;
                            if (tx_bit == 3'd7) begin
                                tx_bit  = '0;
                                tx_byte = tx_byte + 1'b1;
                            end else begin
                                tx_bit = tx_bit + 1'b1;
                            end
                        end
                    end
                end
            end
        endcase
        r.line_out      = line_lvl;
        r.transmitting  = tx_running;
        r.frames_queued = queued;
        return r;
    endfunction

    task automatic send_item(mft_pkg::t_mode m, int unsigned d, int unsigned c,
                             int unsigned idle);
        t_line_item it;
        items_total++;
        it.mode         = m;
        it.data_byte    = d[mft_pkg::BYTE_W-1:0];
        it.collision    = c[0];
        it.channel_idle = idle[0];
        items_to_send.push_back(it);
        line_states_due.push_back(transmitter_step(it));
    endtask

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Inputs change on the falling edge, away from the sampling edge.
    always @(negedge i_clk) begin
        if (phase_left == 0) begin
            steady     = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(50, 300);
        end else begin
            phase_left--;
        end
        if (i_rst_n) begin
            if (item_taken || !item_bus.valid) begin
                if (gap_left != 0) begin
                    item_bus.valid <= 1'b0;
                    gap_left--;
                end else if (items_to_send.size() != 0) begin
                    next_item = items_to_send.pop_front();
                    item_bus.mode         <= next_item.mode;
                    item_bus.data_byte    <= next_item.data_byte;
                    item_bus.collision    <= next_item.collision;
                    item_bus.channel_idle <= next_item.channel_idle;
                    item_bus.valid        <= 1'b1;
                    if (!steady && $urandom_range(0, 2) == 0) begin
                        gap_left = idle_span();
                    end
                end else begin
                    item_bus.valid <= 1'b0;
                end
            end
            if (stall_left != 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                result_bus.ready <= 1'b1;
                if (!steady && $urandom_range(0, 5) == 0) begin
                    stall_left = idle_span();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        item_taken = i_rst_n && item_bus.valid && item_bus.ready;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (line_states_due.size() == 0) begin
                $error("result transfer with no item outstanding");
                error_count++;
            end else begin
                want = line_states_due.pop_front();
                if (result_bus.line_out !== want.line_out) begin
                    $error("line_out: expected %0d, actual %0d",
                           want.line_out, result_bus.line_out);
                    error_count++;
                end
                if (result_bus.transmitting !== want.transmitting) begin
                    $error("transmitting: expected %0d, actual %0d",
                           want.transmitting, result_bus.transmitting);
                    error_count++;
                end
                if (result_bus.accepted !== want.accepted) begin
                    $error("accepted: expected %0d, actual %0d",
                           want.accepted, result_bus.accepted);
                    error_count++;
                end
                if (result_bus.frames_queued !== want.frames_queued) begin
                    $error("frames_queued: expected %0d, actual %0d",
                           want.frames_queued, result_bus.frames_queued);
                    error_count++;
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned roll;
        int unsigned n;
        i_rst_n               = 1'b0;
        item_bus.valid        = 1'b0;
        item_bus.mode         = mft_pkg::MODE_WRITE;
        item_bus.data_byte    = '0;
        item_bus.collision    = 1'b0;
        item_bus.channel_idle = 1'b0;
        result_bus.ready      = 1'b0;
        item_taken            = 1'b0;
        gap_left              = 0;
        stall_left            = 0;
        phase_left            = 0;

        head_q     = '0;
        tail_q     = '0;
        queued     = '0;
        build_len  = '0;
        tx_running = 1'b0;
        tx_byte    = '0;
        tx_bit     = '0;
        tx_half    = 1'b0;
        line_lvl   = 1'b1;

        // Directed: idle-state corners, a short frame with a collision, a full queue.
        send_item(mft_pkg::MODE_START, 8'h00, 1'b0, 1'b1);
        send_item(mft_pkg::MODE_TICK, 8'h00, 1'b0, 1'b1);
        send_item(mft_pkg::MODE_TICK, 8'hFF, 1'b1, 1'b0);
        send_item(mft_pkg::MODE_WRITE, 8'hFF, 1'b0, 1'b0);
        send_item(mft_pkg::MODE_WRITE, 8'h00, 1'b1, 1'b1);
        send_item(mft_pkg::MODE_WRITE, 8'hA5, 1'b0, 1'b0);
        send_item(mft_pkg::MODE_COMMIT, 8'h00, 1'b0, 1'b0);
        send_item(mft_pkg::MODE_START, 8'h00, 1'b0, 1'b0);
        send_item(mft_pkg::MODE_START, 8'h00, 1'b0, 1'b1);
        send_item(mft_pkg::MODE_START, 8'hFF, 1'b1, 1'b1);
        repeat (4) send_item(mft_pkg::MODE_TICK, 8'h00, 1'b0, 1'b1);
        send_item(mft_pkg::MODE_TICK, 8'h00, 1'b1, 1'b1);
        send_item(mft_pkg::MODE_COMMIT, 8'h00, 1'b0, 1'b0);
        send_item(mft_pkg::MODE_START, 8'h00, 1'b0, 1'b1);
        repeat (6) send_item(mft_pkg::MODE_COMMIT, 8'h00, 1'b0, 1'b1);
        send_item(mft_pkg::MODE_COMMIT, 8'hFF, 1'b1, 1'b1);
        send_item(mft_pkg::MODE_WRITE, 8'h3C, 1'b0, 1'b1);

        // Random: mostly short frames built, committed and sent, with rare
        // collisions and a sprinkling of arbitrary items.
        while (items_total < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                send_item(mft_pkg::t_mode'($urandom_range(0, 3)), $urandom_range(0, 255),
                          $urandom_range(0, 1), $urandom_range(0, 1));
            end else if (tx_running) begin
                if (roll < 90) begin
                    send_item(mft_pkg::MODE_TICK, $urandom_range(0, 255),
                              $urandom_range(0, 99) == 0, $urandom_range(0, 1));
                end else if (roll < 95) begin
                    send_item(mft_pkg::MODE_WRITE, $urandom_range(0, 255),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                end else if (roll < 98) begin
                    send_item(mft_pkg::MODE_COMMIT, $urandom_range(0, 255),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                end else begin
                    send_item(mft_pkg::MODE_START, $urandom_range(0, 255),
                              $urandom_range(0, 1), $urandom_range(0, 1));
                end
            end else if (queued != 0 && roll < 45) begin
                send_item(mft_pkg::MODE_START, $urandom_range(0, 255), $urandom_range(0, 1),
                          $urandom_range(0, 3) != 0);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24)
                                                : $urandom_range(0, 4);
                repeat (n) send_item(mft_pkg::MODE_WRITE, $urandom_range(0, 255),
                                     $urandom_range(0, 1), $urandom_range(0, 1));
                send_item(mft_pkg::MODE_COMMIT, $urandom_range(0, 255), $urandom_range(0, 1),
                          $urandom_range(0, 3) != 0);
            end
        end

        // Empty the queue, then fill one frame to the limit and overrun it.
        while (queued != 0) begin
            if (!tx_running) begin
                send_item(mft_pkg::MODE_START, $urandom_range(0, 255), 1'b0, 1'b1);
            end else begin
                send_item(mft_pkg::MODE_TICK, $urandom_range(0, 255), 1'b0,
                          $urandom_range(0, 1));
            end
        end
        while (build_len < FRAME_BYTES) begin
            send_item(mft_pkg::MODE_WRITE, $urandom_range(0, 255), $urandom_range(0, 1),
                      $urandom_range(0, 1));
        end
        repeat (3) send_item(mft_pkg::MODE_WRITE, $urandom_range(0, 255), 1'b0, 1'b1);
        send_item(mft_pkg::MODE_COMMIT, $urandom_range(0, 255), 1'b0, 1'b1);
        repeat (150) send_item(mft_pkg::MODE_TICK, $urandom_range(0, 255), 1'b0, 1'b1);
        send_item(mft_pkg::MODE_TICK, $urandom_range(0, 255), 1'b1, 1'b1);
        send_item(mft_pkg::MODE_START, $urandom_range(0, 255), 1'b0, 1'b1);
        repeat (40) send_item(mft_pkg::MODE_TICK, $urandom_range(0, 255), 1'b0, 1'b1);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (items_to_send.size() != 0 || line_states_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items over %0d cycles: %0d frames completed, %0d collisions,",
                 items_total, cycle_count, frames_sent, collisions_seen);
        $display("%0d writes or commits refused for a full frame or a full queue",
                 rejects_seen);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
